>>> rtl/periodic_task_table_scheduler_top_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared concurrent-check shorthands, clocked on i_clk and gated by i_rst_n.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TABLE_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_TASK_TABLE_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define PTTS_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication
`define PTTS_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

>>> rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Sizes, codes and item/entry types shared by the ring cells and top level.
// ----------------------------------------------------------------------------
package ptts_pkg;

    localparam int TASK_SLOTS = 32;
    localparam int TICK_BITS  = 16;
    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
    localparam int PER_W      = 13;
    localparam int HANDLE_W   = 16;
    localparam int CMP_W      = (TICK_BITS > PER_W) ? TICK_BITS : PER_W;

    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam logic [15:0] DIV10_MUL = 16'd52429;
    localparam int          DIV10_SH  = 19;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_DISP = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_DUE    = 2'd1;
    localparam logic [1:0] KIND_SUM    = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] task_handle;
        logic [15:0] period_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] due_handle;
        logic [5:0]  ran_count;
        logic [5:0]  peak_ran;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [HANDLE_W-1:0]  handle;
        logic [TICK_BITS-1:0] stamp;
        logic [PER_W-1:0]     period;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

>>> rtl/ptts_cell.sv
// ----------------------------------------------------------------------------
// Task ring cell
// Holds one table entry; shifts from its neighbor or takes a direct load.
// ----------------------------------------------------------------------------
module ptts_cell (
    input  logic              i_clk,
    input  ptts_pkg::t_cell_ctl i_ctl,
    input  ptts_pkg::t_entry  i_shift_d,
    input  ptts_pkg::t_entry  i_load_d,
    output ptts_pkg::t_entry  o_q
);

    ptts_pkg::t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_q <= i_shift_d;
        end else if (i_ctl.load) begin
            r_q <= i_load_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/periodic_task_table_scheduler_top.sv
// ----------------------------------------------------------------------------
// Periodic task table scheduler
// Task table held in a rotating ring of cells, scanned one entry per cycle unless a due item stalls.
// ----------------------------------------------------------------------------
// The table lives in a ring of TASK_SLOTS cells that rotates one place per
// cycle of a scan unless a due item stalls; the cell at the head is examined
// each cycle. Add, delete and dispatch each rotate the ring through one full
// turn and then issue a final item from a finishing state; a tick skips the
// turn and goes straight to that state. A dispatch emits one due item per
// task whose elapsed ticks reach its period, then a summary item; the ring
// freezes while a due item cannot be placed in the output register. A new
// item is taken only when the previous one has issued its final item, though
// that item may still wait in the output register.
module periodic_task_table_scheduler_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ptts_pkg::t_in_item  i_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ptts_pkg::t_out_item o_item
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [1:0]                     r_op, n_op;
    logic [ptts_pkg::HANDLE_W-1:0]  r_h, n_h;
    logic [ptts_pkg::PER_W-1:0]     r_per, n_per;
    logic [ptts_pkg::IDX_W-1:0]     r_idx, n_idx;
    logic                           r_found, n_found;
    logic [ptts_pkg::IDX_W-1:0]     r_fidx, n_fidx;
    ptts_pkg::t_entry               r_top, n_top;
    logic [ptts_pkg::CNT_W-1:0]     r_ran, n_ran;
    logic [ptts_pkg::CNT_W-1:0]     r_peak, n_peak;
    logic [ptts_pkg::CNT_W-1:0]     r_live, n_live;
    logic [ptts_pkg::TICK_BITS-1:0] r_now, n_now;
    logic                           r_ov, n_ov;
    ptts_pkg::t_out_item            r_out, n_out;

    ptts_pkg::t_entry               w_q [ptts_pkg::TASK_SLOTS];
    ptts_pkg::t_entry               w_head, w_tail, w_load_d;
    logic                           w_load_en;
    logic [ptts_pkg::IDX_W-1:0]     w_load_idx;
    logic                           w_in_range, w_due, w_can_emit, w_step, w_accept;
    logic [ptts_pkg::TICK_BITS-1:0] w_elapsed;
    logic [31:0]                    w_prod;
    logic [ptts_pkg::CNT_W-1:0]     w_new_peak;

    assign w_head     = w_q[0];
    assign w_in_range = {1'b0, r_idx} < r_live;
    assign w_elapsed  = r_now - w_head.stamp;
    assign w_due      = (r_op == ptts_pkg::OP_DISP) && w_in_range &&
                        (ptts_pkg::CMP_W'(w_elapsed) >= ptts_pkg::CMP_W'(w_head.period));
    assign w_can_emit = !r_ov || i_out_ready;
    assign w_step     = (r_state == S_SCAN) && (!w_due || w_can_emit);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_prod     = {16'd0, i_item.period_ms} * {16'd0, ptts_pkg::DIV10_MUL};
    assign w_new_peak = (r_ran > r_peak) ? r_ran : r_peak;

    // a due task is re-stamped on its way round to the tail
    always_comb begin
        w_tail = w_head;
        if (w_due) begin
            w_tail.stamp = r_now;
        end
    end

    // ring of cells; cell 0 is the head
    for (genvar g = 0; g < ptts_pkg::TASK_SLOTS; g++) begin : g_ring
        ptts_pkg::t_cell_ctl w_ctl;
        ptts_pkg::t_entry    w_sd;
        assign w_ctl.shift = w_step;
        assign w_ctl.load  = w_load_en && (w_load_idx == ptts_pkg::IDX_W'(g));
        if (g == ptts_pkg::TASK_SLOTS - 1) begin : g_tail
            assign w_sd = w_tail;
        end else begin : g_mid
            assign w_sd = w_q[g+1];
        end
        ptts_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_shift_d (w_sd),
            .i_load_d  (w_load_d),
            .o_q       (w_q[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_h     = r_h;
        n_per   = r_per;
        n_idx   = r_idx;
        n_found = r_found;
        n_fidx  = r_fidx;
        n_top   = r_top;
        n_ran   = r_ran;
        n_peak  = r_peak;
        n_live  = r_live;
        n_now   = r_now;
        n_ov    = r_ov && !i_out_ready;
        n_out   = r_out;
        w_load_en  = 1'b0;
        w_load_idx = r_fidx;
        w_load_d   = r_top;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_item.opcode;
                    n_h     = i_item.task_handle;
                    n_per   = w_prod[ptts_pkg::DIV10_SH +: ptts_pkg::PER_W];
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_ran   = '0;
                    n_state = (i_item.opcode == ptts_pkg::OP_TICK) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_step) begin
                    n_idx = r_idx + 1'b1;
                    if (w_in_range && (w_head.handle == r_h) && !r_found) begin
                        n_found = 1'b1;
                        n_fidx  = r_idx;
                    end
                    if ({1'b0, r_idx} == r_live - 1'b1) begin
                        n_top = w_head;
                    end
                    if (w_due) begin
                        n_ran  = r_ran + 1'b1;
                        n_ov   = 1'b1;
                        n_out  = '0;
                        n_out.kind       = ptts_pkg::KIND_DUE;
                        n_out.due_handle = w_head.handle;
                    end
                    if (r_idx == ptts_pkg::IDX_W'(ptts_pkg::TASK_SLOTS - 1)) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (w_can_emit) begin
                    n_ov     = 1'b1;
                    n_out    = '0;
                    n_out.kind = ptts_pkg::KIND_STATUS;
                    n_out.last = 1'b1;
                    n_state  = S_IDLE;
                    case (r_op)
                        ptts_pkg::OP_ADD: begin
                            if (!r_found) begin
                                if (r_live >= ptts_pkg::CNT_W'(ptts_pkg::TASK_SLOTS)) begin
                                    n_out.status = ptts_pkg::ST_FULL;
                                end else begin
                                    w_load_en  = 1'b1;
                                    w_load_idx = r_live[ptts_pkg::IDX_W-1:0];
                                    w_load_d   = '{handle: r_h, stamp: r_now, period: r_per};
                                    n_live     = r_live + 1'b1;
                                end
                            end
                        end
                        ptts_pkg::OP_DEL: begin
                            if (r_found) begin
                                // last entry fills the hole
                                w_load_en = ({1'b0, r_fidx} != r_live - 1'b1);
                                n_live    = r_live - 1'b1;
                            end else begin
                                n_out.status = ptts_pkg::ST_ABSENT;
                            end
                        end
                        ptts_pkg::OP_TICK: begin
                            n_now = r_now + 1'b1;
                        end
                        default: begin
                            n_peak          = w_new_peak;
                            n_out.kind      = ptts_pkg::KIND_SUM;
                            n_out.ran_count = 6'(r_ran);
                            n_out.peak_ran  = 6'(w_new_peak);
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_live  <= '0;
            r_peak  <= '0;
            r_now   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            r_peak  <= n_peak;
            r_now   <= n_now;
            r_ov    <= n_ov;
        end
        r_op    <= n_op;
        r_h     <= n_h;
        r_per   <= n_per;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_fidx  <= n_fidx;
        r_top   <= n_top;
        r_ran   <= n_ran;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_item      = r_out;

    `include "periodic_task_table_scheduler_top_defines.svh"

    `PTTS_AST_IMP(a_live_bound, 1'b1, r_live <= ptts_pkg::CNT_W'(ptts_pkg::TASK_SLOTS))
    `PTTS_AST_IMP(a_ran_bound, r_state == S_SCAN, r_ran <= r_live)
    `PTTS_AST_IMP(a_sum_peak, o_out_valid && o_item.kind == ptts_pkg::KIND_SUM, o_item.peak_ran >= o_item.ran_count)
    `PTTS_AST_NXT(a_fin_done, r_state == S_FIN && w_can_emit, r_state == S_IDLE && o_out_valid && o_item.last)

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Periodic task table scheduler testbench
// Drives add, delete, tick and dispatch items under several idling phases and
// checks every result item against a cycle-free model of the task table.
// ----------------------------------------------------------------------------
module tb;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    ptts_pkg::t_in_item  i_item;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    ptts_pkg::t_out_item o_item;

    periodic_task_table_scheduler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (o_item)
    );

    // 10 time unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model of the task table
    logic [15:0] tbl_handle [ptts_pkg::TASK_SLOTS];
    logic [15:0] tbl_stamp  [ptts_pkg::TASK_SLOTS];
    logic [12:0] tbl_period [ptts_pkg::TASK_SLOTS];
    int          tbl_live;
    int          tbl_peak;
    logic [15:0] tick_now;

    ptts_pkg::t_out_item due_q [$];
    int          err_cnt = 0;
    int          in_idle_pct;
    int          out_stall_pct;
    longint      cyc = 0;

    // handles sent in random adds, so that most deletes name a held task
    logic [15:0] pool [$];

    function automatic int find_handle(logic [15:0] h);
        for (int i = 0; i < tbl_live; i++)
            if (tbl_handle[i] == h) return i;
        return -1;
    endfunction

    function automatic ptts_pkg::t_out_item mk(logic [1:0] k, logic [1:0] s,
                                               logic [15:0] h, logic [5:0] r,
                                               logic [5:0] p, logic l);
        ptts_pkg::t_out_item o;
        o.kind = k; o.status = s; o.due_handle = h;
        o.ran_count = r; o.peak_ran = p; o.last = l;
        return o;
    endfunction

    // work out the result items of one accepted item
    task automatic predict_schedule(ptts_pkg::t_in_item it);
        int idx;
        int ran;
        logic [1:0] st;
        logic [15:0] el;
        case (it.opcode)
            ptts_pkg::OP_ADD: begin
                st = ptts_pkg::ST_OK;
                if (find_handle(it.task_handle) < 0) begin
                    if (tbl_live >= ptts_pkg::TASK_SLOTS) begin
                        st = ptts_pkg::ST_FULL;
                    end else begin
                        tbl_handle[tbl_live] = it.task_handle;
                        tbl_stamp[tbl_live]  = tick_now;
                        tbl_period[tbl_live] = 13'(it.period_ms / 16'd10);
                        tbl_live++;
                    end
                end
                due_q.push_back(mk(ptts_pkg::KIND_STATUS, st, 0, 0, 0, 1'b1));
            end
            ptts_pkg::OP_DEL: begin
                idx = find_handle(it.task_handle);
                st = ptts_pkg::ST_ABSENT;
                if (idx >= 0) begin
                    // last entry fills the hole
                    tbl_handle[idx] = tbl_handle[tbl_live-1];
                    tbl_stamp[idx]  = tbl_stamp[tbl_live-1];
                    tbl_period[idx] = tbl_period[tbl_live-1];
                    tbl_live--;
                    st = ptts_pkg::ST_OK;
                end
                due_q.push_back(mk(ptts_pkg::KIND_STATUS, st, 0, 0, 0, 1'b1));
            end
            ptts_pkg::OP_TICK: begin
                tick_now = tick_now + 16'd1;
                due_q.push_back(mk(ptts_pkg::KIND_STATUS, ptts_pkg::ST_OK, 0, 0, 0, 1'b1));
            end
            default: begin
                ran = 0;
                for (int i = 0; i < tbl_live; i++) begin
                    el = tick_now - tbl_stamp[i];
                    if (el >= {3'b0, tbl_period[i]}) begin
                        tbl_stamp[i] = tick_now;
                        due_q.push_back(mk(ptts_pkg::KIND_DUE, ptts_pkg::ST_OK,
                                           tbl_handle[i], 0, 0, 1'b0));
                        ran++;
                    end
                end
                if (ran > tbl_peak) tbl_peak = ran;
                due_q.push_back(mk(ptts_pkg::KIND_SUM, ptts_pkg::ST_OK, 0,
                                   6'(ran), 6'(tbl_peak), 1'b1));
            end
        endcase
    endtask

    // send one item: valid held until accepted; valid drops only when idling
    task automatic send_item(logic [1:0] op, logic [15:0] h, logic [15:0] p);
        ptts_pkg::t_in_item it;
        it.opcode = op; it.task_handle = h; it.period_ms = p;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_item     <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_schedule(it);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (due_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receiver side: random stall, check at each accepted item
    always @(posedge i_clk) begin
        ptts_pkg::t_out_item e;
        cyc <= cyc + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_q.size() == 0) begin
                $error("result item with no expectation: %h", o_item);
                err_cnt++;
            end else begin
                e = due_q.pop_front();
                if (o_item.kind !== e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_item.kind); err_cnt++;
                end
                if (o_item.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_item.status); err_cnt++;
                end
                if (o_item.due_handle !== e.due_handle) begin
                    $error("due_handle exp %h got %h", e.due_handle, o_item.due_handle);
                    err_cnt++;
                end
                if (o_item.ran_count !== e.ran_count) begin
                    $error("ran_count exp %0d got %0d", e.ran_count, o_item.ran_count);
                    err_cnt++;
                end
                if (o_item.peak_ran !== e.peak_ran) begin
                    $error("peak_ran exp %0d got %0d", e.peak_ran, o_item.peak_ran);
                    err_cnt++;
                end
                if (o_item.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_item.last); err_cnt++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cyc > 2000000) begin
            $display("FAIL periodic_task_table_scheduler_top");
            $finish;
        end
    end

    logic [15:0] fresh_h;

    function automatic logic [15:0] rand_period();
        // mostly short periods so tasks fall due often
        case ($urandom_range(3))
            0: return 16'($urandom_range(0, 9));
            1: return 16'($urandom_range(0, 60));
            2: return 16'($urandom_range(0, 200));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_item(ptts_pkg::OP_DISP, 0, 0);              // empty table
        send_item(ptts_pkg::OP_DEL, 16'h1234, 0);        // absent
        send_item(ptts_pkg::OP_ADD, 16'hFFFF, 16'hFFFF); // extreme fields
        send_item(ptts_pkg::OP_ADD, 16'h0000, 16'd0);    // zero period
        send_item(ptts_pkg::OP_ADD, 16'h0000, 16'd50);   // already present
        send_item(ptts_pkg::OP_ADD, 16'h5555, 16'd25);
        send_item(ptts_pkg::OP_DISP, 0, 0);
        send_item(ptts_pkg::OP_TICK, 16'hAAAA, 16'hAAAA);
        send_item(ptts_pkg::OP_TICK, 0, 0);
        send_item(ptts_pkg::OP_TICK, 0, 0);
        send_item(ptts_pkg::OP_DISP, 0, 0);
        send_item(ptts_pkg::OP_DEL, 16'hFFFF, 0);        // first entry; last entry fills it
        send_item(ptts_pkg::OP_DEL, 16'h5555, 0);        // now the first entry; last fills it
        send_item(ptts_pkg::OP_DISP, 0, 0);
        send_item(ptts_pkg::OP_DEL, 16'h0000, 0);
        // fill past capacity
        for (int i = 0; i < ptts_pkg::TASK_SLOTS + 1; i++)
            send_item(ptts_pkg::OP_ADD, 16'(16'h0100 + i), 16'(i));
        send_item(ptts_pkg::OP_DISP, 0, 0);              // zero-period entries due
        for (int i = 0; i < ptts_pkg::TASK_SLOTS; i++)
            send_item(ptts_pkg::OP_DEL, 16'(16'h0100 + i), 0);
        wait_drain();
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                fresh_h = $urandom_range(15) < 12 ? 16'($urandom_range(40)) : 16'($urandom);
                send_item(ptts_pkg::OP_ADD, fresh_h, rand_period());
                pool.push_back(fresh_h);
            end else if (r < 45) begin
                if (pool.size() != 0 && $urandom_range(3) != 0) begin
                    r = $urandom_range(pool.size() - 1);
                    send_item(ptts_pkg::OP_DEL, pool[r], 16'($urandom));
                    pool.delete(r);
                end else begin
                    send_item(ptts_pkg::OP_DEL, 16'($urandom), 16'($urandom));
                end
            end else if (r < 75) begin
                send_item(ptts_pkg::OP_TICK, 16'($urandom), 16'($urandom));
            end else begin
                send_item(ptts_pkg::OP_DISP, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_item = '0;
        tbl_live = 0;
        tbl_peak = 0;
        tick_now = 0;
        in_idle_pct = 0;
        out_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(50);
        // sender waits for every result before going on
        wait_drain();
        in_idle_pct = 85;
        test_random(50);
        in_idle_pct = 0;
        out_stall_pct = 85;
        test_random(50);
        in_idle_pct = 16;
        out_stall_pct = 16;
        test_random(50);
        out_stall_pct = 0;

        wait_drain();
        if (err_cnt == 0) begin
            $display("PASS periodic_task_table_scheduler_top");
        end else begin
            $display("FAIL periodic_task_table_scheduler_top");
        end
        $finish;
    end
endmodule
